/* rtl/dual_tone_bitwise_mixer_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the dual tone bitwise mixer
// Clocked property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef DUAL_TONE_BITWISE_MIXER_UNIT_ASSERT_SVH
`define DUAL_TONE_BITWISE_MIXER_UNIT_ASSERT_SVH

// Checked on every rising edge of clk, skipped while rst_n is low
`define DTBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included
`define DTBM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/dtbm_pkg.sv */
// ----------------------------------------------------------------------------
// dtbm_pkg
// Constants, types and the quarter-wave sine table of the tone mixer.
// ----------------------------------------------------------------------------
package dtbm_pkg;

    // Widths
    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int QUARTER_LEN     = 1 << TABLE_ADDR_BITS;
    localparam int ROM_ADDR_BITS   = TABLE_ADDR_BITS + 1;
    localparam int MAG_BITS        = 15;
    localparam int SAMPLE_BITS     = 16;
    localparam int STEP_BITS       = 32;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 32;
    localparam int MODE_BITS       = 2;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_A = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_B = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE   = 2'd2;

    // Combine modes
    localparam logic [MODE_BITS-1:0] MODE_AND = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_XOR = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_OR  = 2'd2;

    // pi in 2^-60 fixed point
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    typedef logic [PHASE_BITS-1:0]    phase_t;
    typedef logic [ROM_ADDR_BITS-1:0] rom_addr_t;
    typedef logic [MAG_BITS-1:0]      mag_t;
    typedef logic [SAMPLE_BITS-1:0]   sample_t;

    // Table lookup request, one address per tone
    typedef struct packed {
        rom_addr_t addr_a;
        rom_addr_t addr_b;
        logic      neg_a;
        logic      neg_b;
    } lookup_req_t;

    // Registered table data with its sign flags
    typedef struct packed {
        logic valid;
        mag_t mag_a;
        mag_t mag_b;
        logic neg_a;
        logic neg_b;
    } lookup_rsp_t;

    typedef mag_t sine_rom_t [0:QUARTER_LEN];

    // (a * b) >> 60, elaboration only
    function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[123:60];
    endfunction

    // Unsigned quotient by shift and subtract, elaboration only
    function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // trunc(32767 * sin(pi/2 * k / Q)) by a Taylor series in 2^-60 fixed point
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] half_pi;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        logic [63:0] denom;
        half_pi = PI_Q60 >> 1;
        rom[0] = '0;
        for (int k = 1; k < QUARTER_LEN; k++) begin
            x    = mul_q60(half_pi, 64'(k) << (60 - TABLE_ADDR_BITS));
            x2   = mul_q60(x, x);
            term = x;
            sum  = x;
            for (int n = 1; n <= 13; n++) begin
                denom = 64'((2 * n) * (2 * n + 1));
                term  = div_u64(mul_q60(term, x2), denom);
                if ((n & 1) == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            v = mul_q60(sum, 64'd32767);
            if (v > 64'd32767)
                v = 64'd32767;
            rom[k] = MAG_BITS'(v);
        end
        rom[QUARTER_LEN] = MAG_BITS'(32767);
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

/* rtl/dual_tone_bitwise_mixer_unit.sv */
// ----------------------------------------------------------------------------
// dual_tone_bitwise_mixer_unit
// Two DDS sine oscillators whose 16-bit samples are mixed bitwise.
// ----------------------------------------------------------------------------
// Usage:
//   Tick channel (tick_valid / tick_stall / restart): each transaction is one
//   sample tick. restart = 1 zeroes both phases before the tick's samples.
//   Sample channel (sample_valid / sample_stall): one transaction per tick,
//   carrying tone_a_sample, tone_b_sample and mixed_sample.
//   Config port: cfg_write with cfg_index 0 = tone A tuning word,
//   1 = tone B tuning word, 2 = combine mode (0 AND, 1 XOR, 2 OR, 3 gives
//   zero). Other indexes are ignored. Write only while idle.
// Timing:
//   the sine ROM read register loads at the edge that accepts the tick, and
//   sample_valid rises when the output register then loads from it, which a
//   stalled output can hold back.
//   Throughput is one tick per cycle while no sample is stalled; the phase
//   add, ROM read and combine each fit in one register stage.
// Reset: phases, tuning words and mode clear to zero, pipeline empties.
// Stall: while sample_stall holds a valid sample the whole pipe freezes and
//   tick_stall is raised in the same cycle; nothing is dropped.
// ----------------------------------------------------------------------------
module dual_tone_bitwise_mixer_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [dtbm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [dtbm_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                                    tick_valid,
    output logic                                    tick_stall,
    input  logic                                    restart,
    output logic                                    sample_valid,
    input  logic                                    sample_stall,
    output logic signed [dtbm_pkg::SAMPLE_BITS-1:0] tone_a_sample,
    output logic signed [dtbm_pkg::SAMPLE_BITS-1:0] tone_b_sample,
    output logic signed [dtbm_pkg::SAMPLE_BITS-1:0] mixed_sample
);
    import dtbm_pkg::*;

    logic                 advance;
    logic                 accept;
    logic [MODE_BITS-1:0] mode_reg;
    lookup_req_t          req;
    lookup_rsp_t          rsp;

    // Pipe moves unless a finished sample is held by the receiver
    assign advance    = !(sample_valid && sample_stall);
    assign tick_stall = !advance;
    assign accept     = tick_valid && advance;

    // Combine mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_AND;
        else if (cfg_write && (cfg_index == CFG_MODE))
            mode_reg <= MODE_BITS'(cfg_data);
    end

    dtbm_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .restart   (restart),
        .req       (req)
    );

    dtbm_sine_rom u_rom (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .tick_valid (tick_valid),
        .req        (req),
        .rsp        (rsp)
    );

    dtbm_mix u_mix (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .rsp           (rsp),
        .mode          (mode_reg),
        .sample_valid  (sample_valid),
        .tone_a_sample (tone_a_sample),
        .tone_b_sample (tone_b_sample),
        .mixed_sample  (mixed_sample)
    );

endmodule

/* rtl/dtbm_phase.sv */
// ----------------------------------------------------------------------------
// dtbm_phase
// Tuning word registers, both phase accumulators and table address forming.
// ----------------------------------------------------------------------------
module dtbm_phase (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [dtbm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dtbm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 accept,
    input  logic                                 restart,
    output dtbm_pkg::lookup_req_t                req
);
    import dtbm_pkg::*;

    logic [STEP_BITS-1:0] step_a_reg;
    logic [STEP_BITS-1:0] step_b_reg;
    phase_t               phase_a_reg;
    phase_t               phase_a_next;
    phase_t               phase_b_reg;
    phase_t               phase_b_next;
    phase_t               cur_a;
    phase_t               cur_b;

    // Quadrant mirror: odd quadrants read the table backwards
    function automatic rom_addr_t quad_addr(phase_t ph);
        logic [TABLE_ADDR_BITS-1:0] idx;
        rom_addr_t                  fwd;
        idx = ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];
        fwd = {1'b0, idx};
        if (ph[PHASE_BITS-2])
            return ROM_ADDR_BITS'(QUARTER_LEN) - fwd;
        else
            return fwd;
    endfunction

    // Tuning word registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_a_reg <= '0;
            step_b_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_STEP_A)
                step_a_reg <= STEP_BITS'(cfg_data);
            if (cfg_index == CFG_STEP_B)
                step_b_reg <= STEP_BITS'(cfg_data);
        end
    end

    // Phase used for this tick, restart forces zero
    assign cur_a = restart ? '0 : phase_a_reg;
    assign cur_b = restart ? '0 : phase_b_reg;

    assign phase_a_next = cur_a + PHASE_BITS'(step_a_reg);
    assign phase_b_next = cur_b + PHASE_BITS'(step_b_reg);

    // Accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_a_reg <= '0;
            phase_b_reg <= '0;
        end
        else if (accept)
        begin
            phase_a_reg <= phase_a_next;
            phase_b_reg <= phase_b_next;
        end
    end

    // Lookup request
    assign req.addr_a = quad_addr(cur_a);
    assign req.addr_b = quad_addr(cur_b);
    assign req.neg_a  = cur_a[PHASE_BITS-1];
    assign req.neg_b  = cur_b[PHASE_BITS-1];

endmodule

/* rtl/dtbm_sine_rom.sv */
// ----------------------------------------------------------------------------
// dtbm_sine_rom
// Quarter-wave sine ROM, two registered read ports, one per tone.
// ----------------------------------------------------------------------------
module dtbm_sine_rom (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  tick_valid,
    input  dtbm_pkg::lookup_req_t req,
    output dtbm_pkg::lookup_rsp_t rsp
);
    import dtbm_pkg::*;

    logic valid_reg;
    mag_t mag_a_reg;
    mag_t mag_b_reg;
    logic neg_a_reg;
    logic neg_b_reg;

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= tick_valid;
    end

    // Table reads, held while the pipe is stalled
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mag_a_reg <= SINE_ROM[req.addr_a];
            mag_b_reg <= SINE_ROM[req.addr_b];
            neg_a_reg <= req.neg_a;
            neg_b_reg <= req.neg_b;
        end
    end

    assign rsp.valid = valid_reg;
    assign rsp.mag_a = mag_a_reg;
    assign rsp.mag_b = mag_b_reg;
    assign rsp.neg_a = neg_a_reg;
    assign rsp.neg_b = neg_b_reg;

endmodule

/* rtl/dtbm_mix.sv */
// ----------------------------------------------------------------------------
// dtbm_mix
// Sign restore, bitwise combine and the output register.
// ----------------------------------------------------------------------------
module dtbm_mix (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  dtbm_pkg::lookup_rsp_t            rsp,
    input  logic [dtbm_pkg::MODE_BITS-1:0]   mode,
    output logic                             sample_valid,
    output logic signed [dtbm_pkg::SAMPLE_BITS-1:0] tone_a_sample,
    output logic signed [dtbm_pkg::SAMPLE_BITS-1:0] tone_b_sample,
    output logic signed [dtbm_pkg::SAMPLE_BITS-1:0] mixed_sample
);
    import dtbm_pkg::*;

    sample_t sa;
    sample_t sb;
    sample_t mix;
    logic    valid_reg;
    sample_t tone_a_reg;
    sample_t tone_b_reg;
    sample_t mixed_reg;

    // Signed samples from magnitude and quadrant sign
    assign sa = rsp.neg_a ? -{1'b0, rsp.mag_a} : {1'b0, rsp.mag_a};
    assign sb = rsp.neg_b ? -{1'b0, rsp.mag_b} : {1'b0, rsp.mag_b};

    // Bitwise combine, unused mode gives zero
    always_comb
    begin
        case (mode)
            MODE_AND: mix = sa & sb;
            MODE_XOR: mix = sa ^ sb;
            MODE_OR:  mix = sa | sb;
            default:  mix = '0;
        endcase
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= rsp.valid;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tone_a_reg <= sa;
            tone_b_reg <= sb;
            mixed_reg  <= mix;
        end
    end

    assign sample_valid  = valid_reg;
    assign tone_a_sample = tone_a_reg;
    assign tone_b_sample = tone_b_reg;
    assign mixed_sample  = mixed_reg;

endmodule

/* rtl/dtbm_checker.sv */
// ----------------------------------------------------------------------------
// dtbm_checker
// Port-level assertions for the tone mixer, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_tone_bitwise_mixer_unit_assert.svh"

module dtbm_checker (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    tick_valid,
    input logic                                    tick_stall,
    input logic                                    restart,
    input logic                                    sample_valid,
    input logic                                    sample_stall,
    input logic signed [dtbm_pkg::SAMPLE_BITS-1:0] tone_a_sample,
    input logic signed [dtbm_pkg::SAMPLE_BITS-1:0] tone_b_sample,
    input logic signed [dtbm_pkg::SAMPLE_BITS-1:0] mixed_sample
);
    import dtbm_pkg::*;

    // Ticks are only held back by a stalled, finished sample
    `DTBM_ASSERT_ALWAYS(a_stall_cause, tick_stall |-> (sample_valid && sample_stall), "tick stall without output backpressure")

    // A held sample keeps its mixed and tone A values
    `DTBM_ASSERT(a_hold, (sample_valid && sample_stall) |=> (sample_valid && $stable(mixed_sample) && $stable(tone_a_sample)), "stalled sample changed")

    // Restart tick gives zero samples once the ROM and output registers load, when the pipe moves
    `DTBM_ASSERT(a_restart, (tick_valid && !tick_stall && restart) ##1 (!sample_valid || !sample_stall) |=> (sample_valid && (tone_a_sample == 16'sd0) && (tone_b_sample == 16'sd0)), "restart did not give zero samples")

    // Tone samples never reach the most negative code
    `DTBM_ASSERT(a_range, sample_valid |-> ((tone_a_sample != 16'sh8000) && (tone_b_sample != 16'sh8000)), "tone sample out of range")

    // Equal tones: AND and OR give the tone, XOR and the unused mode give zero
    `DTBM_ASSERT(a_equal_mix, (sample_valid && (tone_a_sample == tone_b_sample)) |-> ((mixed_sample == tone_a_sample) || (mixed_sample == 16'sd0)), "mix of equal tones wrong")

endmodule

bind dual_tone_bitwise_mixer_unit dtbm_checker u_dtbm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_valid    (tick_valid),
    .tick_stall    (tick_stall),
    .restart       (restart),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .tone_a_sample (tone_a_sample),
    .tone_b_sample (tone_b_sample),
    .mixed_sample  (mixed_sample)
);

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: dual tone bitwise mixer testbench
// Drives sample ticks through random gaps and output stalls, and predicts
// both DDS tones and their bitwise mix from a locally built quarter-wave
// table. Every sample transaction is checked in order against the
// prediction. Register settings change between drained phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dtbm_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam int                        CYCLE_LIMIT = 600000;
    localparam int                        MAX_WAIT    = 15;

    typedef struct {
        sample_t tone_a;
        sample_t tone_b;
        sample_t mixed;
    } sample_set_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    // Block inputs, known from time zero
    logic                      cfg_write    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;
    logic                      tick_valid   = 1'b0;
    logic                      restart      = 1'b0;
    logic                      sample_stall = 1'b0;

    logic                          tick_stall;
    logic                          sample_valid;
    logic signed [SAMPLE_BITS-1:0] tone_a_sample;
    logic signed [SAMPLE_BITS-1:0] tone_b_sample;
    logic signed [SAMPLE_BITS-1:0] mixed_sample;

    dual_tone_bitwise_mixer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .restart      (restart),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .tone_a_sample(tone_a_sample),
        .tone_b_sample(tone_b_sample),
        .mixed_sample (mixed_sample)
    );

    // Oscillator model state
    mag_t                     quarter_table [0:QUARTER_LEN];
    phase_t                   osc_phase_a = '0;
    phase_t                   osc_phase_b = '0;
    logic [STEP_BITS-1:0]     tuning_a    = '0;
    logic [STEP_BITS-1:0]     tuning_b    = '0;
    logic [MODE_BITS-1:0]     mix_mode    = MODE_AND;

    bit          pending_ticks [$];
    sample_set_t expected_samples [$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          no_gaps        = 1'b0;
    bit          no_stalls      = 1'b0;
    int          tick_gap       = 0;
    int          stall_left     = 0;

    // Fixed-point helper: keep bits 123:60 of the full product
    function automatic logic [63:0] q60_mul(logic [63:0] lhs, logic [63:0] rhs);
        logic [127:0] wide;
        wide = 128'(lhs) * 128'(rhs);
        return 64'(wide >> 60);
    endfunction

    // trunc(32767 * sin(pi/2 * k/Q)) via odd Taylor terms in 2^-60 fixed point
    function automatic void fill_quarter_table();
        logic [63:0] angle;
        logic [63:0] angle_sq;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] scaled;
        quarter_table[0] = '0;
        for (int k = 1; k < QUARTER_LEN; k++) begin
            angle    = q60_mul(PI_Q60 >> 1, 64'(k) << (60 - TABLE_ADDR_BITS));
            angle_sq = q60_mul(angle, angle);
            term     = angle;
            acc      = angle;
            for (int n = 1; n <= 13; n++) begin
                term = q60_mul(term, angle_sq) / 64'((2 * n) * (2 * n + 1));
                acc  = n[0] ? acc - term : acc + term;
            end
            scaled = q60_mul(acc, 64'd32767);
            quarter_table[k] = (scaled > 64'd32767) ? mag_t'(32767) : mag_t'(scaled);
        end
        quarter_table[QUARTER_LEN] = mag_t'(32767);
    endfunction

    // Quadrant from the top two phase bits, table index from the next bits
    function automatic sample_t tone_value(phase_t ph);
        logic [1:0]                 quad;
        logic [TABLE_ADDR_BITS-1:0] idx;
        sample_t                    mag;
        quad = ph[PHASE_BITS-1 -: 2];
        idx  = ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];
        mag  = quad[0] ? sample_t'(quarter_table[QUARTER_LEN - idx])
                       : sample_t'(quarter_table[idx]);
        return quad[1] ? -mag : mag;
    endfunction

    // One tick of both oscillators; pushes the samples it must produce
    task automatic advance_oscillators(input bit zero_phases);
        sample_set_t s;
        if (zero_phases) begin
            osc_phase_a = '0;
            osc_phase_b = '0;
        end
        s.tone_a = tone_value(osc_phase_a);
        s.tone_b = tone_value(osc_phase_b);
        case (mix_mode)
            MODE_AND: s.mixed = s.tone_a & s.tone_b;
            MODE_XOR: s.mixed = s.tone_a ^ s.tone_b;
            MODE_OR:  s.mixed = s.tone_a | s.tone_b;
            default:  s.mixed = '0;
        endcase
        osc_phase_a = osc_phase_a + phase_t'(tuning_a);
        osc_phase_b = osc_phase_b + phase_t'(tuning_b);
        expected_samples.push_back(s);
    endtask

    // Register write at the next edge, mirrored into the model
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_STEP_A: tuning_a = data;
            CFG_STEP_B: tuning_b = data;
            CFG_MODE:   mix_mode = data[MODE_BITS-1:0];
            default:    ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Wait until every tick is accepted and every sample has come out
    task automatic drain();
        while (pending_ticks.size() != 0 || tick_valid || expected_samples.size() != 0)
            @(negedge clk);
    endtask

    task automatic queue_ticks(input int count);
        for (int i = 0; i < count; i++)
            pending_ticks.push_back($urandom_range(0, 15) == 0);
    endtask

    // Tuning words biased toward the extremes
    function automatic logic [STEP_BITS-1:0] pick_step();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'd1;
            2:       return '1;
            3:       return 32'h8000_0000;
            4:       return 32'h0000_0000 | $urandom_range(0, 4095) << 20;
            default: return $urandom();
        endcase
    endfunction

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Tick driver: one transaction per queued item, random gap after each
    always @(posedge clk) begin : tick_driver
        bit channel_free;
        if (!rst_n) begin
            tick_valid <= 1'b0;
            restart    <= 1'b0;
        end else begin
            channel_free = !tick_valid;
            if (tick_valid && !tick_stall) begin
                advance_oscillators(restart);
                channel_free = 1'b1;
            end
            if (channel_free) begin
                if (tick_gap > 0) begin
                    tick_gap   = tick_gap - 1;
                    tick_valid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    tick_valid <= 1'b1;
                    restart    <= pending_ticks.pop_front();
                    tick_gap   = draw_wait(no_gaps);
                end else begin
                    tick_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string label, input sample_t want, input sample_t got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, label, $signed(want), $signed(got));
            mismatch_count++;
        end
    endtask

    // Sample monitor: compare against the oldest prediction, random stalls
    always @(posedge clk) begin : sample_monitor
        sample_set_t want;
        if (!rst_n) begin
            sample_stall <= 1'b0;
        end else begin
            if (sample_valid && !sample_stall) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected sample transaction, expected none, actual %0d %0d %0d",
                             $time, tone_a_sample, tone_b_sample, mixed_sample);
                    mismatch_count++;
                end else begin
                    want = expected_samples.pop_front();
                    check_field("tone_a_sample", want.tone_a, tone_a_sample);
                    check_field("tone_b_sample", want.tone_b, tone_b_sample);
                    check_field("mixed_sample", want.mixed, mixed_sample);
                end
                stall_left = draw_wait(no_stalls);
            end
            if (stall_left > 0) begin
                stall_left   = stall_left - 1;
                sample_stall <= 1'b1;
            end else begin
                sample_stall <= 1'b0;
            end
        end
    end

    // Run time guard
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        fill_quarter_table();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults: zero tuning words, AND mode
        pending_ticks.push_back(1'b0);
        pending_ticks.push_back(1'b1);
        drain();

        // Quarter and half turn steps land on every quadrant boundary
        write_reg(CFG_STEP_A, 32'h4000_0000);
        write_reg(CFG_STEP_B, 32'h8000_0000);
        write_reg(CFG_MODE, 32'(MODE_XOR));
        @(negedge clk);
        repeat (5) pending_ticks.push_back(1'b0);
        pending_ticks.push_back(1'b1);
        drain();

        // Largest and smallest step, OR via wide mode data, unused index
        write_reg(CFG_STEP_A, '1);
        write_reg(CFG_STEP_B, 32'd1);
        write_reg(CFG_MODE, 32'hFFFF_FFFE);
        write_reg(CFG_UNUSED, '1);
        @(negedge clk);
        repeat (4) pending_ticks.push_back(1'b0);
        drain();

        // Undefined mode gives a zero mix
        write_reg(CFG_MODE, 32'hFFFF_FFFF);
        write_reg(CFG_STEP_A, 32'h4010_0000);
        write_reg(CFG_STEP_B, 32'hC000_0000);
        @(negedge clk);
        repeat (3) pending_ticks.push_back(1'b0);
        drain();

        // AND mode through masked data, with a restart mid-stream
        write_reg(CFG_MODE, 32'hFFFF_FFFC);
        @(negedge clk);
        pending_ticks.push_back(1'b0);
        pending_ticks.push_back(1'b0);
        pending_ticks.push_back(1'b1);
        pending_ticks.push_back(1'b0);
        drain();

        // Random phases: new settings, then a random-length tick stream
        for (int p = 0; p < 12; p++) begin
            if ($urandom_range(0, 3) != 0) write_reg(CFG_STEP_A, pick_step());
            if ($urandom_range(0, 3) != 0) write_reg(CFG_STEP_B, pick_step());
            if ($urandom_range(0, 3) != 0) write_reg(CFG_MODE, $urandom());
            if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, $urandom());
            no_gaps   = ($urandom_range(0, 3) == 0);
            no_stalls = ($urandom_range(0, 3) == 0);
            @(negedge clk);
            queue_ticks($urandom_range(100, 140));
            drain();
        end

        repeat (8) @(negedge clk);
        if (expected_samples.size() != 0) begin
            $display("%0t: %0d expected samples never arrived", $time, expected_samples.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

/* dual_tone_bitwise_mixer_unit.f */
+incdir+rtl
rtl/dtbm_pkg.sv
rtl/dtbm_phase.sv
rtl/dtbm_sine_rom.sv
rtl/dtbm_mix.sv
rtl/dual_tone_bitwise_mixer_unit.sv
rtl/dtbm_checker.sv
dv/tb_top.sv
